// File: src/xor_hex_frame_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// xor_hex_frame_deframer_top_macros.svh
// Assertion shorthands shared by the deframer modules. Each macro expects a
// clock named aclk and an active-low reset named aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef XOR_HEX_FRAME_DEFRAMER_TOP_MACROS_SVH
`define XOR_HEX_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication.
`define XHFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("deframer assertion failed");

// Next-cycle implication.
`define XHFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("deframer assertion failed");

`endif

// File: src/xhfd_pkg.sv
// ----------------------------------------------------------------------------
// xhfd_pkg
// Shared types, character codes and phase codes of the frame deframer.
// ----------------------------------------------------------------------------
package xhfd_pkg;

    localparam int BUFFER_SIZE_DEF = 4096;
    localparam int OUT_W           = 12;

    localparam logic [7:0] START_MARK   = 8'h40;  // '@'
    localparam logic [7:0] END_MARK     = 8'h7E;  // '~'
    localparam logic [7:0] DIGIT_SPLIT  = 8'd58;  // '9' + 1
    localparam logic [8:0] OFS_NUMERIC  = 9'd48;
    localparam logic [8:0] OFS_ALPHA    = 9'd55;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DIGIT1  = 2'd2;
    localparam logic [1:0] PH_DIGIT2  = 2'd3;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic [OUT_W-1:0] payload_index;
        logic             frame_done;
        logic             checksum_ok;
        logic [OUT_W-1:0] frame_length;
        logic             frame_dropped;
    } result_t;

    // Hex digit value, -48..200; out-of-range characters are not rejected.
    function automatic logic signed [8:0] digit_value(input logic [7:0] c);
        logic [8:0] c_ext;
        c_ext = {1'b0, c};
        if (c < DIGIT_SPLIT) begin
            return $signed(c_ext - OFS_NUMERIC);
        end
        return $signed(c_ext - OFS_ALPHA);
    endfunction

endpackage

// File: src/xor_hex_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// xor_hex_frame_deframer_top
// Parser for '@' payload '~' H H frames with an XOR checksum in two hex
// digits; streams payload bytes and reports frame end, length and overflow.
// ----------------------------------------------------------------------------
// The block takes one received byte per transfer and sustains one byte per
// clock while the output is not stalled. Each byte is decoded in the input
// register, where the frame state is updated, and its result (payload byte,
// frame summary or drop flag) is loaded into the result register that drives
// m_valid. Bytes that produce nothing (start and end marks, the first checksum
// digit, idle noise) still pass the input register but never wait on the
// output side. The parser updates its state once per processed byte, which
// sets this rate; a stalled m_ready holds the result register and, once the
// input register also holds an item that yields a result, drops s_ready.
// BUFFER_SIZE sets the payload limit: a frame may carry at most BUFFER_SIZE-1
// bytes, and the reported position and length are the low 12 bits of the count.
// ----------------------------------------------------------------------------
`include "xor_hex_frame_deframer_top_macros.svh"

module xor_hex_frame_deframer_top #(
    parameter int BUFFER_SIZE = xhfd_pkg::BUFFER_SIZE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_rx_byte,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_payload_valid,
    output logic [7:0]                 m_payload_byte,
    output logic [xhfd_pkg::OUT_W-1:0] m_payload_index,
    output logic                       m_frame_done,
    output logic                       m_checksum_ok,
    output logic [xhfd_pkg::OUT_W-1:0] m_frame_length,
    output logic                       m_frame_dropped
);
    import xhfd_pkg::*;

    // Input register stage.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;

    logic    advance;     // the byte in the input register is processed now
    logic    has_result;  // that byte yields a result
    logic    out_free;    // result register can take a new result
    result_t res_comb;
    result_t res_q;

    // A byte without a result never waits on the output side; a byte with a
    // result waits only while the result register is full and stalled.
    assign advance = in_valid_reg && (!has_result || out_free);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the byte on every input transfer; hold it otherwise.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    xhfd_parser #(
        .BUFFER_SIZE(BUFFER_SIZE)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (byte_reg),
        .has_result(has_result),
        .res       (res_comb)
    );

    // Load a result only when the processed byte produced one.
    xhfd_out_reg u_out_reg (
        .aclk   (aclk),
        .aresetn(aresetn),
        .load   (advance && has_result),
        .res_in (res_comb),
        .m_ready(m_ready),
        .m_valid(m_valid),
        .free   (out_free),
        .res_out(res_q)
    );

    assign m_payload_valid = res_q.payload_valid;
    assign m_payload_byte  = res_q.payload_byte;
    assign m_payload_index = res_q.payload_index;
    assign m_frame_done    = res_q.frame_done;
    assign m_checksum_ok   = res_q.checksum_ok;
    assign m_frame_length  = res_q.frame_length;
    assign m_frame_dropped = res_q.frame_dropped;

    // A waiting byte with a result must stay put while the output is stalled.
    `XHFD_ASSERT_NEXT(a_hold_input, in_valid_reg && !advance,
        in_valid_reg && $stable(byte_reg))
    `XHFD_ASSERT_IMPL(a_no_load_when_full, advance && has_result, !m_valid || m_ready)
    // Hold a stalled result transfer unchanged.
    `XHFD_ASSERT_NEXT(a_hold_output, m_valid && !m_ready, m_valid && $stable(res_q))

endmodule

// File: src/xhfd_parser.sv
// ----------------------------------------------------------------------------
// xhfd_parser
// Frame state and per-byte decode: phase, payload count, running XOR and
// first checksum digit, updated once per stepped byte.
// ----------------------------------------------------------------------------
`include "xor_hex_frame_deframer_top_macros.svh"

module xhfd_parser #(
    parameter int BUFFER_SIZE = xhfd_pkg::BUFFER_SIZE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              has_result,
    output xhfd_pkg::result_t res
);
    import xhfd_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_SIZE);
    localparam int EXT_W = (CNT_W > OUT_W) ? CNT_W : OUT_W;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_SIZE - 1);

    logic [1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        xor_reg, xor_next;
    logic signed [8:0] digit_reg, digit_next;

    logic [CNT_W-1:0]   count_inc;
    logic [EXT_W-1:0]   inc_ext;
    logic [EXT_W-1:0]   cnt_ext;
    logic signed [13:0] total;
    logic signed [13:0] xor_ext;

    assign count_inc = CNT_W'(count_reg + 1'b1);
    assign inc_ext   = EXT_W'(count_inc);
    assign cnt_ext   = EXT_W'(count_reg);
    assign total     = (14'(digit_reg) <<< 4) + 14'(digit_value(rx_byte));
    assign xor_ext   = $signed({6'b0, xor_reg});

    // Decode the presented byte every cycle; the state only moves on step.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        digit_next = digit_reg;
        has_result = 1'b0;
        res        = '0;
        priority if (rx_byte == START_MARK) begin
            phase_next = PH_PAYLOAD;
            count_next = '0;
            xor_next   = '0;
        end else if (rx_byte == END_MARK) begin
            if (phase_reg == PH_PAYLOAD) begin
                phase_next = PH_DIGIT1;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                end
                PH_PAYLOAD: begin
                    has_result = 1'b1;
                    if (count_reg >= LIMIT) begin
                        phase_next        = PH_IDLE;
                        res.frame_dropped = 1'b1;
                    end else begin
                        count_next        = count_inc;
                        xor_next          = xor_reg ^ rx_byte;
                        res.payload_valid = 1'b1;
                        res.payload_byte  = rx_byte;
                        res.payload_index = inc_ext[OUT_W-1:0];
                    end
                end
                PH_DIGIT1: begin
                    digit_next = digit_value(rx_byte);
                    phase_next = PH_DIGIT2;
                end
                PH_DIGIT2: begin
                    has_result       = 1'b1;
                    phase_next       = PH_IDLE;
                    res.frame_done   = 1'b1;
                    res.checksum_ok  = (total == xor_ext);
                    res.frame_length = cnt_ext[OUT_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            xor_reg   <= '0;
            digit_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
            digit_reg <= digit_next;
        end
    end

    `XHFD_ASSERT_IMPL(a_one_kind, has_result,
        $onehot({res.payload_valid, res.frame_done, res.frame_dropped}))
    `XHFD_ASSERT_IMPL(a_done_from_digit2, step && res.frame_done, phase_reg == PH_DIGIT2)
    `XHFD_ASSERT_NEXT(a_start_clears, step && rx_byte == START_MARK,
        phase_reg == PH_PAYLOAD && count_reg == '0 && xor_reg == '0)
    `XHFD_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= LIMIT)

endmodule

// File: src/xhfd_out_reg.sv
// ----------------------------------------------------------------------------
// xhfd_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module xhfd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  xhfd_pkg::result_t res_in,
    input  logic              m_ready,
    output logic              m_valid,
    output logic              free,
    output xhfd_pkg::result_t res_out
);
    import xhfd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign res_out = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule
